// ===== hdl/u16u8_pkg.sv =====
// shared types, constants and byte-sequence helpers for the utf-16 to utf-8 encoder
`timescale 1ns / 1ps
`default_nettype none

package u16u8_pkg;

  localparam int RUN_MAX = 7;
  localparam int IDX_W   = 3;
  localparam int SEG_MAX = 4;

  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;
  localparam logic [20:0] TWO_BYTE   = 21'h80;
  localparam logic [20:0] THREE_BYTE = 21'h800;

  // bytes of one code point, first byte in b[0]
  typedef struct packed {
    logic [SEG_MAX-1:0][7:0] b;
    logic [2:0]              len;
  } seg_t;

  // all bytes caused by one input word, first byte in bytes[0]
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [IDX_W-1:0]        cnt;
    logic                    term;
  } run_t;

  function automatic seg_t enc_cp(input logic [20:0] cp);
    seg_t s;
    s = '0;
    if (cp < TWO_BYTE) begin
      s.b[0] = {1'b0, cp[6:0]};
      s.len  = 3'd1;
    end else if (cp < THREE_BYTE) begin
      s.b[0] = {3'b110, cp[10:6]};
      s.b[1] = {2'b10, cp[5:0]};
      s.len  = 3'd2;
    end else if (cp < SUPP_BASE) begin
      s.b[0] = {4'b1110, cp[15:12]};
      s.b[1] = {2'b10, cp[11:6]};
      s.b[2] = {2'b10, cp[5:0]};
      s.len  = 3'd3;
    end else begin
      s.b[0] = {5'b11110, cp[20:18]};
      s.b[1] = {2'b10, cp[17:12]};
      s.b[2] = {2'b10, cp[11:6]};
      s.b[3] = {2'b10, cp[5:0]};
      s.len  = 3'd4;
    end
    return s;
  endfunction

  function automatic run_t append(input run_t r, input seg_t s);
    run_t       o;
    logic [3:0] pos;
    o = r;
    for (int i = 0; i < SEG_MAX; i++) begin
      pos = {1'b0, r.cnt} + 4'(i);
      if (4'(i) < {1'b0, s.len} && pos < 4'(RUN_MAX)) begin
        o.bytes[pos[IDX_W-1:0]] = s.b[i];
      end
    end
    o.cnt = r.cnt + s.len;
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/utf16_to_utf8_encoder.sv =====
// utf-16 to utf-8 (wtf-8 style) encoder, top level
// a word's bytes pass from the pending run register to the output run register, then out
// throughput: one output byte per cycle while m_tready is high; a word causes 1 to 7 bytes
//   (up to 3 for plain bmp text), sent on the single output byte port
// a word that causes no byte queues no run and only updates surrogate and stop state
// rst (synchronous, active high) drops any pending bytes and clears the held surrogate
`timescale 1ns / 1ps
`default_nettype none

module utf16_to_utf8_encoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // code_unit
  input  wire logic        s_tuser,   // unit_present
  input  wire logic        s_tlast,   // end_of_string
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // out_byte
  output logic             m_tlast,   // run_last
  output logic             m_tuser    // terminator
);

  logic            pend_valid;
  u16u8_pkg::run_t pend;
  logic            take;

  u16u8_encode u_encode (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .pend_valid (pend_valid),
    .pend       (pend),
    .take       (take)
  );

  u16u8_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .pend_valid (pend_valid),
    .pend       (pend),
    .take       (take),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule

`default_nettype wire

// ===== hdl/u16u8_encode.sv =====
// surrogate tracking and per-word byte assembly into a pending run register
`timescale 1ns / 1ps
`default_nettype none

module u16u8_encode (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [15:0]      s_tdata,   // code_unit
  input  wire logic             s_tuser,   // unit_present
  input  wire logic             s_tlast,   // end_of_string
  output logic                  pend_valid,
  output u16u8_pkg::run_t       pend,
  input  wire logic             take
);

  logic            held_valid;
  logic [9:0]      held_bits;
  logic            stopped;
  logic            held_mid;
  logic [9:0]      bits_mid;
  logic            stopped_mid;
  logic            active;
  logic            is_low;
  logic            is_high;
  logic            paired;
  logic            accept;
  u16u8_pkg::run_t run_next;
  u16u8_pkg::seg_t term_seg;

  assign is_low  = s_tdata >= u16u8_pkg::LOW_FIRST && s_tdata <= u16u8_pkg::LOW_LAST;
  assign is_high = s_tdata >= u16u8_pkg::HIGH_FIRST && s_tdata <= u16u8_pkg::HIGH_LAST;
  assign active  = s_tuser && !stopped;
  assign s_tready = !rst && (!pend_valid || take);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    term_seg     = '0;
    term_seg.len = 3'd1;
    run_next     = '0;
    held_mid     = held_valid;
    bits_mid     = held_bits;
    stopped_mid  = stopped;
    paired       = 1'b0;
    // resolve a waiting high surrogate against this word
    if (active && held_valid) begin
      if (is_low) begin
        run_next = u16u8_pkg::append(run_next, u16u8_pkg::enc_cp(
          u16u8_pkg::SUPP_BASE + {1'b0, held_bits, s_tdata[9:0]}));
        paired = 1'b1;
      end else begin
        run_next = u16u8_pkg::append(run_next, u16u8_pkg::enc_cp(
          {5'd0, u16u8_pkg::HIGH_FIRST[15:10], held_bits}));
      end
      held_mid = 1'b0;
      bits_mid = '0;
    end
    if (active && !paired) begin
      if (s_tdata == 16'd0) begin
        stopped_mid = 1'b1;
      end else if (is_high) begin
        held_mid = 1'b1;
        bits_mid = s_tdata[9:0];
      end else begin
        run_next = u16u8_pkg::append(run_next, u16u8_pkg::enc_cp({5'd0, s_tdata}));
      end
    end
    // end of string: flush and close with a zero byte
    if (s_tlast) begin
      if (held_mid) begin
        run_next = u16u8_pkg::append(run_next, u16u8_pkg::enc_cp(
          {5'd0, u16u8_pkg::HIGH_FIRST[15:10], bits_mid}));
      end
      run_next      = u16u8_pkg::append(run_next, term_seg);
      run_next.term = 1'b1;
      held_mid      = 1'b0;
      bits_mid      = '0;
      stopped_mid   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_bits  <= '0;
      stopped    <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (accept) begin
        held_valid <= held_mid;
        held_bits  <= bits_mid;
        stopped    <= stopped_mid;
      end
      if (take) begin
        pend_valid <= 1'b0;
      end
      if (accept && run_next.cnt != '0) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && run_next.cnt != '0) begin
      pend <= run_next;
    end
  end

`ifndef SYNTH
  a_pend_nonempty : assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> pend.cnt != '0)
    else $error("pending run with no bytes");
  a_held_not_stopped : assert property (@(posedge clk) disable iff (rst)
    held_valid |-> !stopped)
    else $error("surrogate held while output is stopped");
  a_end_clears : assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (!held_valid && !stopped && pend_valid && pend.term))
    else $error("string end did not clear state or queue terminator");
`endif

endmodule

`default_nettype wire

// ===== hdl/u16u8_serial.sv =====
// output run buffer sending one byte per handshake
`timescale 1ns / 1ps
`default_nettype none

module u16u8_serial (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             pend_valid,
  input  wire u16u8_pkg::run_t  pend,
  output logic                  take,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [7:0]            m_tdata,   // out_byte
  output logic                  m_tlast,   // run_last
  output logic                  m_tuser    // terminator
);

  u16u8_pkg::run_t                 run;
  logic                            run_valid;
  logic [u16u8_pkg::IDX_W-1:0]     idx;
  logic                            last_byte;

  assign last_byte = idx == run.cnt - 3'd1;
  assign take      = pend_valid && (!run_valid || (m_tready && last_byte));
  assign m_tvalid  = run_valid;
  assign m_tdata   = run.bytes[idx];
  assign m_tlast   = last_byte;
  assign m_tuser   = last_byte && run.term;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      idx       <= '0;
    end else if (take) begin
      run_valid <= 1'b1;
      idx       <= '0;
    end else if (run_valid && m_tready) begin
      if (last_byte) begin
        run_valid <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      run <= pend;
    end
  end

`ifndef SYNTH
  a_idx_in_run : assert property (@(posedge clk) disable iff (rst)
    run_valid |-> idx < run.cnt)
    else $error("byte index past end of run");
  a_hold_on_stall : assert property (@(posedge clk) disable iff (rst)
    (run_valid && !m_tready) |=> (run_valid && $stable(idx)))
    else $error("run advanced while output stalled");
`endif

endmodule

`default_nettype wire

// ===== verif/utf16_to_utf8_encoder_tb.sv =====
// self-checking testbench for the utf-16 to utf-8 encoder
`timescale 1ns / 1ps

module utf16_to_utf8_encoder_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 250;
  localparam int WORD_TARGET = 110;

  localparam logic [15:0] HIGH_LO = 16'hD800;
  localparam logic [15:0] HIGH_HI = 16'hDBFF;
  localparam logic [15:0] LOW_LO  = 16'hDC00;
  localparam logic [15:0] LOW_HI  = 16'hDFFF;

  // unit categories for the random strings
  typedef enum int {
    K_ASCII, K_TWO, K_THREE, K_PAIR, K_HIGH, K_LOW, K_NUL, K_EMPTY, K_NOISE
  } unit_kind_e;

  typedef struct packed {
    logic [15:0] unit;
    logic        present;
    logic        eos;
  } utf16_word_t;

  typedef struct packed {
    logic [7:0] val;
    logic       run_end;
    logic       closing;
  } utf8_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = 16'h0000;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  utf16_word_t unsent_words[$];
  utf8_byte_t  utf8_due[$];
  utf8_byte_t  run_buf[$];

  // encoder state as predicted
  logic       held_valid = 1'b0;
  logic [9:0] held_bits = '0;
  logic       nul_seen = 1'b0;

  int          total_words = 0;
  int          words_in = 0;
  int          bad_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          rx_phase = 0;
  int          idle_cycles = 0;
  bit          word_taken = 1'b0;
  utf16_word_t next_word;
  utf8_byte_t  want;

  utf16_to_utf8_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // code_unit
    .s_tuser  (s_tuser),   // unit_present
    .s_tlast  (s_tlast),   // end_of_string
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // out_byte
    .m_tlast  (m_tlast),   // run_last
    .m_tuser  (m_tuser)    // terminator
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    bad_count++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic add_byte(input logic [7:0] b, input logic closing);
    utf8_byte_t e;
    e.val     = b;
    e.run_end = 1'b0;
    e.closing = closing;
    run_buf.push_back(e);
  endtask

  task automatic add_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      add_byte(cp[7:0], 1'b0);
    end else if (cp < 21'h800) begin
      add_byte(8'hC0 | 8'(cp >> 6), 1'b0);
      add_byte(8'h80 | 8'(cp & 21'h3F), 1'b0);
    end else if (cp < 21'h10000) begin
      add_byte(8'hE0 | 8'(cp >> 12), 1'b0);
      add_byte(8'h80 | 8'((cp >> 6) & 21'h3F), 1'b0);
      add_byte(8'h80 | 8'(cp & 21'h3F), 1'b0);
    end else begin
      add_byte(8'hF0 | 8'(cp >> 18), 1'b0);
      add_byte(8'h80 | 8'((cp >> 12) & 21'h3F), 1'b0);
      add_byte(8'h80 | 8'((cp >> 6) & 21'h3F), 1'b0);
      add_byte(8'h80 | 8'(cp & 21'h3F), 1'b0);
    end
  endtask

  // a waiting high surrogate goes out as itself
  task automatic flush_high();
    if (held_valid) begin
      add_code_point({5'd0, 6'b110110, held_bits});
      held_valid = 1'b0;
      held_bits  = '0;
    end
  endtask

  task automatic transcode_word(input utf16_word_t w);
    logic paired;
    paired = 1'b0;
    run_buf.delete();
    if (w.present && !nul_seen) begin
      if (held_valid) begin
        if (w.unit >= LOW_LO && w.unit <= LOW_HI) begin
          add_code_point(21'h10000 + {1'b0, held_bits, w.unit[9:0]});
          held_valid = 1'b0;
          held_bits  = '0;
          paired     = 1'b1;
        end else begin
          flush_high();
        end
      end
      if (!paired) begin
        if (w.unit == 16'h0000) begin
          nul_seen = 1'b1;
        end else if (w.unit >= HIGH_LO && w.unit <= HIGH_HI) begin
          held_valid = 1'b1;
          held_bits  = w.unit[9:0];
        end else begin
          add_code_point({5'd0, w.unit});
        end
      end
    end
    if (w.eos) begin
      flush_high();
      add_byte(8'h00, 1'b1);
      nul_seen = 1'b0;
    end
    if (run_buf.size() > 0) begin
      run_buf[run_buf.size()-1].run_end = 1'b1;
    end
    foreach (run_buf[i]) begin
      utf8_due.push_back(run_buf[i]);
    end
  endtask

  task automatic queue_word(input logic [15:0] unit, input logic present, input logic eos);
    utf16_word_t w;
    w.unit    = unit;
    w.present = present;
    w.eos     = eos;
    unsent_words.push_back(w);
  endtask

  function automatic logic [15:0] pick_unit(input unit_kind_e kind);
    case (kind)
      K_ASCII: return 16'($urandom_range(1, 16'h7F));
      K_TWO:   return 16'($urandom_range(16'h80, 16'h7FF));
      K_THREE: begin
        if ($urandom_range(0, 1) == 0) return 16'($urandom_range(16'h800, 16'hD7FF));
        return 16'($urandom_range(16'hE000, 16'hFFFF));
      end
      K_PAIR, K_HIGH: return 16'($urandom_range(HIGH_LO, HIGH_HI));
      K_LOW:   return 16'($urandom_range(LOW_LO, LOW_HI));
      K_NUL:   return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic unit_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 19);
    if (r < 6) return K_ASCII;
    if (r < 9) return K_TWO;
    if (r < 12) return K_THREE;
    if (r < 15) return K_PAIR;
    if (r == 15) return K_HIGH;
    if (r == 16) return K_LOW;
    if (r == 17) return K_NUL;
    if (r == 18) return K_EMPTY;
    return K_NOISE;
  endfunction

  // hold-off starts once the random part is under way
  function automatic int directed_words_mark();
    return 40;
  endfunction

  // stimulus, reset and end of run
  initial begin
    int         len;
    unit_kind_e kind;

    // encoding lengths at their boundaries
    queue_word(16'h007F, 1'b1, 1'b0);
    queue_word(16'h0080, 1'b1, 1'b0);
    queue_word(16'h07FF, 1'b1, 1'b0);
    queue_word(16'h0800, 1'b1, 1'b0);
    queue_word(16'hFFFF, 1'b1, 1'b0);
    // lowest and highest surrogate pairs
    queue_word(16'hD800, 1'b1, 1'b0);
    queue_word(16'hDC00, 1'b1, 1'b0);
    queue_word(16'hDBFF, 1'b1, 1'b0);
    queue_word(16'hDFFF, 1'b1, 1'b0);
    // high followed by a plain unit, then a lone low
    queue_word(16'hD834, 1'b1, 1'b0);
    queue_word(16'h0041, 1'b1, 1'b0);
    queue_word(16'hDC05, 1'b1, 1'b0);
    // high after high, empty word keeps the second held, then it pairs
    queue_word(16'hDABC, 1'b1, 1'b0);
    queue_word(16'hD9FF, 1'b1, 1'b0);
    queue_word(16'hA5A5, 1'b0, 1'b0);
    queue_word(16'hDC00, 1'b1, 1'b0);
    queue_word(16'h20AC, 1'b1, 1'b1);
    // flushed high plus three-byte unit plus terminator: longest run
    queue_word(16'hDBFF, 1'b1, 1'b0);
    queue_word(16'hE000, 1'b1, 1'b1);
    // zero unit with a held high, then everything dropped until the end
    queue_word(16'hD800, 1'b1, 1'b0);
    queue_word(16'h0000, 1'b1, 1'b0);
    queue_word(16'h1234, 1'b1, 1'b0);
    queue_word(16'hD800, 1'b1, 1'b0);
    queue_word(16'h5A5A, 1'b0, 1'b0);
    queue_word(16'h0041, 1'b1, 1'b1);
    // empty final word flushes a held high
    queue_word(16'hD83D, 1'b1, 1'b0);
    queue_word(16'hFFFF, 1'b0, 1'b1);

    // random strings, mostly well formed, some noise
    while (unsent_words.size() < WORD_TARGET) begin
      len = $urandom_range(0, 7);
      for (int k = 0; k < len; k++) begin
        kind = pick_kind();
        if (kind == K_EMPTY) begin
          queue_word(16'($urandom()), 1'b0, 1'b0);
        end else begin
          queue_word(pick_unit(kind), 1'b1, 1'b0);
          if (kind == K_PAIR) queue_word(pick_unit(K_LOW), 1'b1, 1'b0);
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        queue_word(16'($urandom()), 1'b0, 1'b1);
      end else begin
        kind = pick_kind();
        queue_word(pick_unit(kind), 1'b1, 1'b1);
      end
    end
    total_words = unsent_words.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (words_in < total_words) @(posedge clk);
    while (utf8_due.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (bad_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // sender: bursts of words with random gaps
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || word_taken) begin
      if (gap_left > 0 || unsent_words.size() == 0) begin
        if (gap_left > 0) gap_left--;
        s_tvalid <= 1'b0;
      end else begin
        next_word = unsent_words.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= next_word.unit;
        s_tuser  <= next_word.present;
        s_tlast  <= next_word.eos;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // receiver: rotating stall pattern plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && words_in >= directed_words_mark()) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      rx_phase++;
      case ((rx_phase / 48) % 4)
        0:       m_tready <= 1'b1;
        1:       m_tready <= 1'($urandom_range(0, 1));
        2:       m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // checker: outputs compared first, then the accepted word predicted
  always @(posedge clk) begin
    word_taken = s_tvalid && s_tready && !rst;
    if (m_tvalid && m_tready && !rst) begin
      if (utf8_due.size() == 0) begin
        report_mismatch($sformatf("byte %02h last=%0b term=%0b with nothing expected",
                                  m_tdata, m_tlast, m_tuser));
      end else begin
        want = utf8_due.pop_front();
        if (m_tdata !== want.val || m_tlast !== want.run_end || m_tuser !== want.closing) begin
          report_mismatch($sformatf("byte %02h last=%0b term=%0b, wanted %02h %0b %0b",
                                    m_tdata, m_tlast, m_tuser,
                                    want.val, want.run_end, want.closing));
        end
      end
    end
    if (word_taken) begin
      next_word_check: begin
        utf16_word_t w;
        w.unit    = s_tdata;
        w.present = s_tuser;
        w.eos     = s_tlast;
        transcode_word(w);
      end
      words_in++;
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
